// ----- rtl/core/twce_pkg.sv -----
package twce_pkg;

	localparam int unsigned ROW_W = 6;
	localparam int unsigned COL_W = 8;
	localparam int unsigned CHR_W = 8;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [COL_W-1:0] TAB_STEP = COL_W'(4);

	localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHR_W-1:0] CH_HT    = 8'h09;
	localparam logic [CHR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [COL_W-1:0] LEFT_RST   = 8'd0;
	localparam logic [COL_W-1:0] RIGHT_RST  = 8'd79;
	localparam logic [ROW_W-1:0] BOTTOM_RST = 6'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_COLUMN  = 2'd0,
		CFG_RIGHT_COLUMN = 2'd1,
		CFG_BOTTOM_ROW   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_CHAR   = 1'b0,
		REQ_SET    = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [COL_W-1:0] left_column;
		logic [COL_W-1:0] right_column;
		logic [ROW_W-1:0] bottom_row;
	} window_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
	} cursor_t;

	typedef struct packed {
		logic             write_enable;
		logic [ROW_W-1:0] write_row;
		logic [COL_W-1:0] write_column;
		logic [CHR_W-1:0] write_glyph;
		logic             scroll_request;
		cursor_t          cursor;
	} result_t;

endpackage

// ----- rtl/core/twce_req_if.sv -----
interface twce_req_if
	import twce_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [CHR_W-1:0] char_code;
	logic [ROW_W-1:0] set_row;
	logic [COL_W-1:0] set_column;

	modport source (output valid, req_type, char_code, set_row, set_column, input ready);
	modport sink (input valid, req_type, char_code, set_row, set_column, output ready);
endinterface

// ----- rtl/core/twce_res_if.sv -----
interface twce_res_if
	import twce_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic             write_enable;
	logic [ROW_W-1:0] write_row;
	logic [COL_W-1:0] write_column;
	logic [CHR_W-1:0] write_glyph;
	logic             scroll_request;
	logic [ROW_W-1:0] cursor_row;
	logic [COL_W-1:0] cursor_column;

	modport source (output valid, write_enable, write_row, write_column, write_glyph,
		scroll_request, cursor_row, cursor_column, input ready);
	modport sink (input valid, write_enable, write_row, write_column, write_glyph,
		scroll_request, cursor_row, cursor_column, output ready);
endinterface

// ----- rtl/core/twce_cfg_if.sv -----
interface twce_cfg_if
	import twce_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/twce_step.sv -----
module twce_step
	import twce_pkg::*;
(
	input  logic             req_type,
	input  logic [CHR_W-1:0] char_code,
	input  logic [ROW_W-1:0] set_row,
	input  logic [COL_W-1:0] set_column,
	input  cursor_t          cursor,
	input  window_t          window,
	output result_t          result
);

	// one extra bit on each: a row can step twice, a column can run past 255
	logic [ROW_W:0] row;
	logic [COL_W:0] col;
	logic           we;
	logic [CHR_W-1:0] glyph;
	logic           scroll;
	logic [COL_W:0] left_w;

	always_comb begin
		left_w = {1'b0, window.left_column};
		row    = {1'b0, cursor.row};
		col    = {1'b0, cursor.column};
		we     = 1'b0;
		glyph  = '0;
		scroll = 1'b0;
		result = '0;

		if (req_kind_t'(req_type) == REQ_SET) begin
			row = {1'b0, set_row};
			col = {1'b0, set_column};
		end else begin
			unique case (char_code)
				CH_LF: begin
					col = left_w;
					row = row + 1'b1;
				end
				CH_CR: begin
					col = left_w;
				end
				CH_HT: begin
					col = col + {1'b0, TAB_STEP};
				end
				CH_VT: begin
					row = row + 1'b1;
				end
				CH_FF: begin
					row = row + 1'b1;
					col = left_w;
				end
				CH_BS: begin
					if (col <= left_w) begin
						col = left_w;
					end else begin
						col = col - 1'b1;
					end
					we    = 1'b1;
					glyph = CH_SPACE;
				end
				default: begin
					we    = 1'b1;
					glyph = char_code;
					col   = col + 1'b1;
				end
			endcase

			if (we) begin
				// the write lands before the column advance for glyphs
				result.write_row    = cursor.row;
				result.write_column = (char_code == CH_BS) ? col[COL_W-1:0] : cursor.column;
			end

			if (col > {1'b0, window.right_column}) begin
				col = left_w;
				row = row + 1'b1;
			end
			if (row > {1'b0, window.bottom_row}) begin
				scroll = 1'b1;
				col    = left_w;
				row    = {1'b0, window.bottom_row};
			end
		end

		result.write_enable   = we;
		result.write_glyph    = glyph;
		result.scroll_request = scroll;
		result.cursor.row     = row[ROW_W-1:0];
		result.cursor.column  = col[COL_W-1:0];
	end

endmodule

// ----- rtl/core/text_window_cursor_engine.sv -----
// channel | dir | handshake   | payload
// req     | in  | valid/ready | req_type, char_code, set_row, set_column
// res     | out | valid/ready | write_*, scroll_request, cursor_row, cursor_column
// cfg     | in  | valid/ready | index, data (0 left, 1 right, 2 bottom)
//
// One request per cycle unless res stalls; its result enters the result register next cycle.
// The cursor update is one compare/increment path between the request and that register.
// A request is taken while the result register is empty or being drained in the same cycle.
// Reset clears the cursor to row 0, column 0 and loads the default window; cfg is always ready.
module text_window_cursor_engine
	import twce_pkg::*;
(
	input logic clk,
	input logic arst_n,
	twce_req_if.sink   req,
	twce_res_if.source res,
	twce_cfg_if.sink   cfg
);

	window_t window_q;
	cursor_t cursor_q;
	result_t result_s1;
	result_t next_result;
	logic    valid_s1;
	logic    take;

	assign req.ready = ~valid_s1 | res.ready;
	assign take      = req.valid & req.ready;
	assign cfg.ready = 1'b1;

	twce_step u_step (
		.req_type   (req.req_type),
		.char_code  (req.char_code),
		.set_row    (req.set_row),
		.set_column (req.set_column),
		.cursor     (cursor_q),
		.window     (window_q),
		.result     (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.left_column  <= LEFT_RST;
			window_q.right_column <= RIGHT_RST;
			window_q.bottom_row   <= BOTTOM_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_LEFT_COLUMN:  window_q.left_column  <= cfg.data;
				CFG_RIGHT_COLUMN: window_q.right_column <= cfg.data;
				CFG_BOTTOM_ROW:   window_q.bottom_row   <= cfg.data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				cursor_q <= next_result.cursor;
				valid_s1 <= 1'b1;
			end else if (res.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s1 <= next_result;
		end
	end

	assign res.valid          = valid_s1;
	assign res.write_enable   = result_s1.write_enable;
	assign res.write_row      = result_s1.write_row;
	assign res.write_column   = result_s1.write_column;
	assign res.write_glyph    = result_s1.write_glyph;
	assign res.scroll_request = result_s1.scroll_request;
	assign res.cursor_row     = result_s1.cursor.row;
	assign res.cursor_column  = result_s1.cursor.column;

endmodule
